FILE: rtl/xcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcf_pkg: shared definitions for the XOR-checked command framer
// Holds the reset value of the start delimiter and the result record that
// travels from the frame sequencer to the output register.
// ----------------------------------------------------------------------------
package xcf_pkg;

	localparam logic [7:0] START_DELIM_RESET = 8'h02;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       run_last;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/xcf_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcf_seq: input register and frame sequencer
// Holds one input transaction and, while res_ready is high, emits its bytes
// one per cycle, keeping the open-frame state (bytes left, running XOR).
// ----------------------------------------------------------------------------
module xcf_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             starts_frame,
	input  wire logic [7:0]       frame_code,
	input  wire logic [15:0]      payload_length,
	input  wire logic [7:0]       data_byte,
	input  wire logic [7:0]       start_delimiter,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output xcf_pkg::result_t      res
);

	localparam logic [2:0] K_DELIM  = 3'd0;
	localparam logic [2:0] K_CODE   = 3'd1;
	localparam logic [2:0] K_LEN_LO = 3'd2;
	localparam logic [2:0] K_LEN_HI = 3'd3;
	localparam logic [2:0] K_DATA   = 3'd4;
	localparam logic [2:0] K_CHECK  = 3'd5;

	logic        valid_s1;
	logic        start_s1;
	logic [7:0]  code_s1;
	logic [15:0] len_s1;
	logic [7:0]  data_s1;

	logic [2:0]  idx_q;
	logic [15:0] bytes_left_q;
	logic [7:0]  running_xor_q;
	logic        frame_open_q;

	logic [2:0]  kind;
	logic        last;
	logic [7:0]  byte_val;
	logic [7:0]  xor_base;
	logic        fire;
	logic        drop;
	logic        item_done;
	logic        len_zero;
	logic        len_one;

	assign len_zero = (len_s1 == 16'd0);
	assign len_one  = (len_s1 == 16'd1);

	always_comb begin
		res_valid = 1'b0;
		kind      = K_DATA;
		last      = 1'b0;
		if (valid_s1) begin
			if (start_s1) begin
				res_valid = 1'b1;
				case (idx_q)
					3'd0: kind = K_DELIM;
					3'd1: kind = K_CODE;
					3'd2: kind = K_LEN_LO;
					3'd3: kind = K_LEN_HI;
					3'd4: begin
						kind = len_zero ? K_CHECK : K_DATA;
						last = !len_one;
					end
					default: begin
						kind = K_CHECK;
						last = 1'b1;
					end
				endcase
			end else if (frame_open_q) begin
				res_valid = 1'b1;
				if (idx_q == 3'd0) begin
					kind = K_DATA;
					last = (bytes_left_q > 16'd1);
				end else begin
					kind = K_CHECK;
					last = 1'b1;
				end
			end
		end
	end

	always_comb begin
		case (kind)
			K_DELIM:  byte_val = start_delimiter;
			K_CODE:   byte_val = code_s1;
			K_LEN_LO: byte_val = len_s1[7:0];
			K_LEN_HI: byte_val = len_s1[15:8];
			K_DATA:   byte_val = data_s1;
			K_CHECK:  byte_val = running_xor_q;
			default:  byte_val = data_s1;
		endcase
	end

	// The checksum restarts with the delimiter of a new frame.
	assign xor_base = (start_s1 && idx_q == 3'd0) ? 8'h00 : running_xor_q;

	assign res.out_byte  = byte_val;
	assign res.frame_end = (kind == K_CHECK);
	assign res.run_last  = last;

	assign fire      = res_valid && res_ready;
	assign drop      = valid_s1 && !start_s1 && !frame_open_q;
	assign item_done = drop || (fire && last);
	assign in_ready  = !valid_s1 || item_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			start_s1 <= starts_frame;
			code_s1  <= frame_code;
			len_s1   <= payload_length;
			data_s1  <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= 3'd0;
			bytes_left_q  <= 16'd0;
			running_xor_q <= 8'h00;
			frame_open_q  <= 1'b0;
		end else if (fire) begin
			idx_q <= last ? 3'd0 : idx_q + 3'd1;
			if (kind == K_CHECK) begin
				running_xor_q <= 8'h00;
				bytes_left_q  <= 16'd0;
				frame_open_q  <= 1'b0;
			end else begin
				running_xor_q <= xor_base ^ byte_val;
				if (kind == K_DELIM) begin
					frame_open_q <= 1'b1;
				end
				if (kind == K_DATA) begin
					// A start item loads the count; later items count it down.
					bytes_left_q <= start_s1 ? len_s1 - 16'd1 : bytes_left_q - 16'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/xcf_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcf_out_reg: result register
// Holds one result byte for the serial side and takes the next one in the
// same cycle that the held one is accepted.
// ----------------------------------------------------------------------------
module xcf_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             res_valid,
	output logic                  res_ready,
	input  wire xcf_pkg::result_t res,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            out_byte,
	output logic                  frame_end,
	output logic                  run_last
);

	logic             out_valid_q;
	xcf_pkg::result_t res_q;

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = res_q.out_byte;
	assign frame_end = res_q.frame_end;
	assign run_last  = res_q.run_last;

endmodule
`default_nettype wire

FILE: rtl/xor_checked_command_framer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xor_checked_command_framer_core: serial command frame builder
// Frames are delimiter, code, 16-bit length (low byte first), payload and an
// XOR check byte over all earlier bytes of the frame.
// ----------------------------------------------------------------------------
//   Channel  Handshake               Payload
//   input    in_valid / in_ready     starts_frame, frame_code, payload_length,
//                                    data_byte
//   output   out_valid / out_ready   out_byte, frame_end, run_last
//   config   cfg_wr_en               cfg_wr_data (start delimiter)
//
// A payload transaction emits its data byte, followed by the check byte when
// it closes the frame. A start transaction emits the header bytes and then
// its first data byte, the check byte, or both, by payload length.
// A transaction dropped with no frame open emits no byte.
// Reset clears the open frame and sets the delimiter to 0x02.
// A stall on the output holds the sequencer; the input register keeps one
// transaction and the result register one result byte.
// ----------------------------------------------------------------------------
module xor_checked_command_framer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        starts_frame,
	input  wire logic [7:0]  frame_code,
	input  wire logic [15:0] payload_length,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             frame_end,
	output logic             run_last,
	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data
);

	logic [7:0]       start_delimiter_q;
	logic             emit_valid;
	logic             emit_ready;
	xcf_pkg::result_t emit_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delimiter_q <= xcf_pkg::START_DELIM_RESET;
		end else if (cfg_wr_en) begin
			start_delimiter_q <= cfg_wr_data;
		end
	end

	xcf_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.starts_frame    (starts_frame),
		.frame_code      (frame_code),
		.payload_length  (payload_length),
		.data_byte       (data_byte),
		.start_delimiter (start_delimiter_q),
		.res_valid       (emit_valid),
		.res_ready       (emit_ready),
		.res             (emit_res)
	);

	xcf_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (emit_valid),
		.res_ready (emit_ready),
		.res       (emit_res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.frame_end (frame_end),
		.run_last  (run_last)
	);

	// A byte waiting on a full result register must still be offered next cycle.
	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid && !emit_ready |=> emit_valid)
		else $error("sequencer withdrew a stalled byte");

	// The check byte always closes the transaction that caused it.
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last)
		else $error("check byte not marked as last of its transaction");

	// With nothing offered, an accepted result leaves the register empty.
	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !emit_valid |=> !out_valid)
		else $error("result register kept a stale byte");

endmodule
`default_nettype wire
